// ===== rtl/nfe_pkg.sv =====
// ----------------------------------------------------------------------------
// nfe_pkg: shared types and constants of the nuclei field evaluator
// Payload structs, controller commands, status flags, result codes and the
// integer part table of exp(-n).
// ----------------------------------------------------------------------------
package nfe_pkg;

   // input operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_ON_NUC = 2'd1;
   localparam logic [1:0] STAT_ZERO_W = 2'd2;
   localparam logic [1:0] STAT_SAT    = 2'd3;

   // configuration register indexes (paddr[2])
   localparam logic REG_NUM_NUCLEI  = 1'b0;
   localparam logic REG_ACTIVE_DIMS = 1'b1;

   // shared divider and square root widths
   localparam int DivNW  = 68;
   localparam int DivDW  = 48;
   localparam int DivQW  = 40;
   localparam int DivCW  = 7;
   localparam int SqrtSW = 66;
   localparam int SqrtRW = 33;

   typedef struct packed {
      logic               op;
      logic        [5:0]  slot;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] charge;
      logic        [23:0] gauss_width;
      logic signed [31:0] length_scale;
      logic signed [31:0] length_offset;
   } req_type;

   typedef struct packed {
      logic signed [31:0] potential;
      logic        [16:0] density;
      logic signed [31:0] mesh_length;
      logic        [5:0]  nearest_slot;
      logic        [1:0]  status;
   } rsp_type;

   // controller to datapath commands
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_READ,
      CMD_SQUARE,
      CMD_ADD,
      CMD_EVAL,
      CMD_DIV_START,
      CMD_ACCUM,
      CMD_NEXT,
      CMD_READ_BEST,
      CMD_WIDTH,
      CMD_DDIV_START,
      CMD_TAY_INIT,
      CMD_TAY_MUL,
      CMD_TAY_DIV_START,
      CMD_TAY_ACC,
      CMD_EXP_MUL,
      CMD_DENS,
      CMD_MESH_MUL,
      CMD_MESH_ADD,
      CMD_PUBLISH
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_query;
      logic s_zero;
      logic q_zero;
      logic last_nucleus;
      logic last_dim;
      logic width_zero;
      logic out_of_range;
      logic last_term;
      logic sqrt_busy;
      logic div_busy;
   } dp_status_type;

   // round(exp(-n) * 2^30)
   function automatic logic [30:0] exp_int(input logic [3:0] n);
      logic [30:0] v;
      case (n)
         4'd0:    v = 31'd1073741824;
         4'd1:    v = 31'd395007542;
         4'd2:    v = 31'd145315154;
         4'd3:    v = 31'd53458458;
         4'd4:    v = 31'd19666268;
         4'd5:    v = 31'd7234815;
         4'd6:    v = 31'd2661540;
         4'd7:    v = 31'd979126;
         4'd8:    v = 31'd360200;
         4'd9:    v = 31'd132510;
         4'd10:   v = 31'd48748;
         4'd11:   v = 31'd17933;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/nfe_div.sv =====
// ----------------------------------------------------------------------------
// nfe_div: shared restoring divider
// One quotient bit per cycle. The numerator arrives left aligned; steps
// gives how many of its leading bits are consumed.
// ----------------------------------------------------------------------------
module nfe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nfe_pkg::DivNW-1:0]  num,
   input  logic [nfe_pkg::DivDW-1:0]  den,
   input  logic [nfe_pkg::DivCW-1:0]  steps,
   output logic                       busy,
   output logic [nfe_pkg::DivQW-1:0]  quo
);

   logic                      busy_ff, busy_in;
   logic [nfe_pkg::DivNW-1:0] num_ff, num_in;
   logic [nfe_pkg::DivDW-1:0] den_ff, den_in;
   logic [nfe_pkg::DivDW-1:0] rem_ff, rem_in;
   logic [nfe_pkg::DivQW-1:0] quo_ff, quo_in;
   logic [nfe_pkg::DivCW-1:0] cnt_ff, cnt_in;
   logic [nfe_pkg::DivDW:0]   rsh;
   logic [nfe_pkg::DivDW:0]   diff;

   // trial subtract of the shifted partial remainder
   assign rsh  = {rem_ff, num_ff[nfe_pkg::DivNW-1]};
   assign diff = rsh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = steps;
      end else if (busy_ff) begin
         num_in = {num_ff[nfe_pkg::DivNW-2:0], 1'b0};
         if (!diff[nfe_pkg::DivDW]) begin
            rem_in = diff[nfe_pkg::DivDW-1:0];
            quo_in = {quo_ff[nfe_pkg::DivQW-2:0], 1'b1};
         end else begin
            rem_in = rsh[nfe_pkg::DivDW-1:0];
            quo_in = {quo_ff[nfe_pkg::DivQW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == nfe_pkg::DivCW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/nfe_isqrt.sv =====
// ----------------------------------------------------------------------------
// nfe_isqrt: iterative integer square root
// Digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module nfe_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nfe_pkg::SqrtSW-1:0]  radicand,
   output logic                        busy,
   output logic [nfe_pkg::SqrtRW-1:0]  root
);

   localparam int RemW = nfe_pkg::SqrtRW + 2;

   logic                       busy_ff, busy_in;
   logic [nfe_pkg::SqrtSW-1:0] s_ff, s_in;
   logic [RemW-1:0]            rem_ff, rem_in;
   logic [nfe_pkg::SqrtRW-1:0] root_ff, root_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic [RemW+1:0]            rsh;
   logic [RemW+1:0]            trial;
   logic [RemW+1:0]            diff;

   // trial value 4*root+1 against the remainder with two new bits
   assign rsh   = {rem_ff, s_ff[nfe_pkg::SqrtSW-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign diff  = rsh - trial;

   always_comb begin
      busy_in = busy_ff;
      s_in    = s_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         s_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'(nfe_pkg::SqrtRW);
      end else if (busy_ff) begin
         s_in = {s_ff[nfe_pkg::SqrtSW-3:0], 2'b00};
         if (rsh >= trial) begin
            rem_in  = diff[RemW-1:0];
            root_in = {root_ff[nfe_pkg::SqrtRW-2:0], 1'b1};
         end else begin
            rem_in  = rsh[RemW-1:0];
            root_in = {root_ff[nfe_pkg::SqrtRW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      s_ff    <= s_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/nfe_dpath.sv =====
// ----------------------------------------------------------------------------
// nfe_dpath: nucleus table and arithmetic datapath
// Holds the nucleus memories, distance accumulation, potential sum, nearest
// search, Gaussian density series and mesh length, driven by commands.
// ----------------------------------------------------------------------------
module nfe_dpath #(
   parameter int MAX_NUCLEI = 64,
   parameter int MAX_DIMS   = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nfe_pkg::cmd_type       cmd,
   input  nfe_pkg::req_type       req_data,
   input  logic [6:0]             num_nuclei,
   input  logic [1:0]             active_dims,
   output nfe_pkg::dp_status_type status,
   output nfe_pkg::rsp_type       rsp_data
);

   localparam int IW  = (MAX_NUCLEI > 1) ? $clog2(MAX_NUCLEI) : 1;
   localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int AW  = 43 + IW;
   localparam int RW  = MAX_DIMS * 32;

   // nucleus memories
   logic [RW-1:0] coord_mem  [MAX_NUCLEI];
   logic [15:0]   charge_mem [MAX_NUCLEI];
   logic [23:0]   width_mem  [MAX_NUCLEI];
   logic [31:0]   scale_mem  [MAX_NUCLEI];
   logic [31:0]   offset_mem [MAX_NUCLEI];

   logic [RW-1:0] rd_row_ff;
   logic [15:0]   rd_charge_ff;
   logic [23:0]   rd_width_ff;
   logic [31:0]   rd_scale_ff;
   logic [31:0]   rd_offset_ff;

   logic [31:0]   pin [3];
   logic [RW-1:0] wr_row;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;
   logic          rd_en;

   logic [31:0]   pt_ff [MAX_DIMS];
   logic [IW-1:0] idx_ff;
   logic [DIW-1:0] dim_ff;
   logic [IW-1:0] last_idx;
   logic [DIW-1:0] last_dim_idx;

   logic [65:0]   sq_ff;
   logic [65:0]   s_ff;
   logic [65:0]   best_s_ff;
   logic [IW-1:0] best_ff;
   logic          zero_hit_ff;
   logic          sat_set_ff;
   logic          sat_neg_ff;
   logic          zero_w_ff;
   logic          sat_pot_ff;
   logic          sat_mesh_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [31:0]   pot_ff;
   logic [47:0]   wsq_ff;
   logic [3:0]    q0_ff;
   logic [30:0]   term_ff;
   logic [29:0]   t30_ff;
   logic [60:0]   tprod_ff;
   logic signed [33:0] sum_ff;
   logic [3:0]    k_ff;
   logic [63:0]   eprod_ff;
   logic [16:0]   dens_ff;
   logic signed [49:0] mprod_ff;
   logic signed [31:0] mesh_ff;
   nfe_pkg::rsp_type   rsp_ff;

   // point inputs as an array
   assign pin[0] = req_data.point_x;
   assign pin[1] = req_data.point_y;
   assign pin[2] = req_data.point_z;

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         wr_row[d*32 +: 32] = pin[d];
      end
   end

   assign wr_en   = (cmd == nfe_pkg::CMD_ACCEPT) && (req_data.op == nfe_pkg::OP_LOAD) &&
                    (32'(req_data.slot) < MAX_NUCLEI);
   assign wr_addr = IW'(req_data.slot);
   assign rd_en   = (cmd == nfe_pkg::CMD_READ) || (cmd == nfe_pkg::CMD_READ_BEST);
   assign rd_addr = (cmd == nfe_pkg::CMD_READ_BEST) ? best_ff : idx_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem[wr_addr]  <= wr_row;
         charge_mem[wr_addr] <= req_data.charge;
         width_mem[wr_addr]  <= req_data.gauss_width;
         scale_mem[wr_addr]  <= req_data.length_scale;
         offset_mem[wr_addr] <= req_data.length_offset;
      end
      if (rd_en) begin
         rd_row_ff    <= coord_mem[rd_addr];
         rd_charge_ff <= charge_mem[rd_addr];
         rd_width_ff  <= width_mem[rd_addr];
         rd_scale_ff  <= scale_mem[rd_addr];
         rd_offset_ff <= offset_mem[rd_addr];
      end
   end

   // clamped register values
   always_comb begin
      if (num_nuclei == 7'd0) begin
         last_idx = '0;
      end else if (32'(num_nuclei) > MAX_NUCLEI) begin
         last_idx = IW'(MAX_NUCLEI - 1);
      end else begin
         last_idx = IW'(num_nuclei - 7'd1);
      end
      if (active_dims == 2'd0) begin
         last_dim_idx = '0;
      end else if (32'(active_dims) > MAX_DIMS) begin
         last_dim_idx = DIW'(MAX_DIMS - 1);
      end else begin
         last_dim_idx = DIW'(active_dims - 2'd1);
      end
   end

   // one coordinate difference squared
   logic [31:0]        coord_sel;
   logic signed [32:0] diff;
   logic [32:0]        absd;
   logic [65:0]        sq_c;

   assign coord_sel = rd_row_ff[dim_ff*32 +: 32];
   assign diff      = $signed({pt_ff[dim_ff][31], pt_ff[dim_ff]}) -
                      $signed({coord_sel[31], coord_sel});
   assign absd      = diff[32] ? 33'(-diff) : 33'(diff);
   assign sq_c      = absd * absd;

   // charge sign and magnitude
   logic signed [15:0] q_s;
   logic [15:0]        absq;
   logic               q_zero;
   logic               q_pos;

   assign q_s    = $signed(rd_charge_ff);
   assign absq   = q_s[15] ? 16'(-q_s) : 16'(q_s);
   assign q_zero = (rd_charge_ff == 16'd0);
   assign q_pos  = !q_s[15] && !q_zero;

   // shared iterative units
   logic                        sq_start;
   logic                        sq_busy;
   logic [nfe_pkg::SqrtRW-1:0]  sq_root;
   logic                        div_start;
   logic [nfe_pkg::DivNW-1:0]   div_num;
   logic [nfe_pkg::DivDW-1:0]   div_den;
   logic [nfe_pkg::DivCW-1:0]   div_steps;
   logic                        div_busy;
   logic [nfe_pkg::DivQW-1:0]   div_quo;

   assign sq_start = (cmd == nfe_pkg::CMD_EVAL);

   nfe_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (s_ff),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   // divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      div_steps = '0;
      case (cmd)
         nfe_pkg::CMD_DIV_START: begin
            div_start = 1'b1;
            div_num   = {absq, 52'b0};
            div_den   = 48'(sq_root);
            div_steps = nfe_pkg::DivCW'(40);
         end
         nfe_pkg::CMD_DDIV_START: begin
            div_start = 1'b1;
            div_num   = {best_s_ff[51:0], 16'b0};
            div_den   = wsq_ff;
            div_steps = nfe_pkg::DivCW'(68);
         end
         nfe_pkg::CMD_TAY_DIV_START: begin
            div_start = 1'b1;
            div_num   = {tprod_ff[60:30], 37'b0};
            div_den   = 48'(k_ff);
            div_steps = nfe_pkg::DivCW'(31);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   nfe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // combinational helpers
   logic [47:0]        wsq_c;
   logic [51:0]        w12;
   logic               out_of_range;
   logic [60:0]        tprod_c;
   logic [32:0]        sum_pos;
   logic [63:0]        eprod_c;
   logic [63:0]        vr;
   logic [33:0]        dr;
   logic signed [17:0] dfac;
   logic signed [49:0] mprod_c;
   logic signed [49:0] mr;
   logic signed [33:0] mq;
   logic signed [34:0] msum;
   logic               mesh_ovf;
   logic               pot_ovf;

   assign wsq_c        = rd_width_ff * rd_width_ff;
   assign w12          = {1'b0, wsq_ff, 3'b0} + {2'b0, wsq_ff, 2'b0};
   assign out_of_range = (best_s_ff[65:64] != 2'b00) || (best_s_ff[63:0] >= 64'(w12));
   assign tprod_c      = term_ff * t30_ff;
   assign sum_pos      = sum_ff[33] ? 33'd0 : sum_ff[32:0];
   assign eprod_c      = nfe_pkg::exp_int(q0_ff) * sum_pos;
   assign vr           = eprod_ff + 64'd536870912;
   assign dr           = vr[63:30] + 34'd8192;
   assign dfac         = 18'sd65536 - $signed({1'b0, dens_ff});
   assign mprod_c      = $signed(rd_scale_ff) * dfac;
   assign mr           = mprod_ff + 50'sd32768;
   assign mq           = mr[49:16];
   assign msum         = $signed({mq[33], mq}) +
                         $signed({{3{rd_offset_ff[31]}}, rd_offset_ff});
   assign mesh_ovf     = (msum[34:31] != {4{msum[31]}});
   assign pot_ovf      = (acc_ff[AW-1:31] != {(AW-31){acc_ff[31]}});

   // command execution
   always_ff @(posedge clock) begin
      case (cmd)
         nfe_pkg::CMD_ACCEPT: begin
            for (int d = 0; d < MAX_DIMS; d++) begin
               pt_ff[d] <= pin[d];
            end
            idx_ff      <= '0;
            best_ff     <= '0;
            best_s_ff   <= '0;
            zero_hit_ff <= 1'b0;
            sat_set_ff  <= 1'b0;
            sat_neg_ff  <= 1'b0;
            zero_w_ff   <= 1'b0;
            sat_pot_ff  <= 1'b0;
            sat_mesh_ff <= 1'b0;
            acc_ff      <= '0;
            pot_ff      <= '0;
            dens_ff     <= '0;
            mesh_ff     <= '0;
         end
         nfe_pkg::CMD_READ: begin
            dim_ff <= '0;
            s_ff   <= '0;
         end
         nfe_pkg::CMD_SQUARE: begin
            sq_ff <= sq_c;
         end
         nfe_pkg::CMD_ADD: begin
            s_ff   <= s_ff + sq_ff;
            dim_ff <= dim_ff + 1'b1;
         end
         nfe_pkg::CMD_EVAL: begin
            // nearest search, lowest slot wins ties
            if (idx_ff == '0 || s_ff < best_s_ff) begin
               best_ff   <= idx_ff;
               best_s_ff <= s_ff;
            end
            if (s_ff == '0) begin
               zero_hit_ff <= 1'b1;
               if (!sat_set_ff && !q_zero) begin
                  sat_set_ff <= 1'b1;
                  sat_neg_ff <= q_pos;
               end
            end
         end
         nfe_pkg::CMD_ACCUM: begin
            if (q_pos) begin
               acc_ff <= acc_ff - AW'(div_quo);
            end else begin
               acc_ff <= acc_ff + AW'(div_quo);
            end
         end
         nfe_pkg::CMD_NEXT: begin
            idx_ff <= idx_ff + 1'b1;
         end
         nfe_pkg::CMD_READ_BEST: begin
            // final potential
            if (sat_set_ff) begin
               pot_ff <= sat_neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else if (pot_ovf) begin
               pot_ff     <= acc_ff[AW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
               sat_pot_ff <= 1'b1;
            end else begin
               pot_ff <= acc_ff[31:0];
            end
         end
         nfe_pkg::CMD_WIDTH: begin
            wsq_ff <= wsq_c;
            if (rd_width_ff == 24'd0) begin
               zero_w_ff <= 1'b1;
            end
         end
         nfe_pkg::CMD_TAY_INIT: begin
            q0_ff   <= div_quo[19:16];
            t30_ff  <= {div_quo[15:0], 14'b0};
            term_ff <= 31'h40000000;
            sum_ff  <= 34'sh40000000;
            k_ff    <= 4'd1;
         end
         nfe_pkg::CMD_TAY_MUL: begin
            tprod_ff <= tprod_c;
         end
         nfe_pkg::CMD_TAY_ACC: begin
            term_ff <= div_quo[30:0];
            if (k_ff[0]) begin
               sum_ff <= sum_ff - $signed({3'b0, div_quo[30:0]});
            end else begin
               sum_ff <= sum_ff + $signed({3'b0, div_quo[30:0]});
            end
            k_ff <= k_ff + 4'd1;
         end
         nfe_pkg::CMD_EXP_MUL: begin
            eprod_ff <= eprod_c;
         end
         nfe_pkg::CMD_DENS: begin
            dens_ff <= dr[30:14];
         end
         nfe_pkg::CMD_MESH_MUL: begin
            mprod_ff <= mprod_c;
         end
         nfe_pkg::CMD_MESH_ADD: begin
            if (mesh_ovf) begin
               mesh_ff     <= msum[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
               sat_mesh_ff <= 1'b1;
            end else begin
               mesh_ff <= msum[31:0];
            end
         end
         nfe_pkg::CMD_PUBLISH: begin
            rsp_ff.potential    <= pot_ff;
            rsp_ff.density      <= dens_ff;
            rsp_ff.mesh_length  <= mesh_ff;
            rsp_ff.nearest_slot <= 6'(best_ff);
            if (zero_hit_ff) begin
               rsp_ff.status <= nfe_pkg::STAT_ON_NUC;
            end else if (zero_w_ff) begin
               rsp_ff.status <= nfe_pkg::STAT_ZERO_W;
            end else if (sat_pot_ff || sat_mesh_ff) begin
               rsp_ff.status <= nfe_pkg::STAT_SAT;
            end else begin
               rsp_ff.status <= nfe_pkg::STAT_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // status to controller
   assign status.req_query    = (req_data.op == nfe_pkg::OP_QUERY);
   assign status.s_zero       = (s_ff == '0);
   assign status.q_zero       = q_zero;
   assign status.last_nucleus = (idx_ff == last_idx);
   assign status.last_dim     = (dim_ff == last_dim_idx);
   assign status.width_zero   = (rd_width_ff == 24'd0);
   assign status.out_of_range = out_of_range;
   assign status.last_term    = (k_ff == 4'd12);
   assign status.sqrt_busy    = sq_busy;
   assign status.div_busy     = div_busy;

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/nfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfe_ctrl: sequencer of the nuclei field evaluator
// Walks the nucleus table for a query, runs the density series and owns the
// input and result handshakes.
// ----------------------------------------------------------------------------
module nfe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  nfe_pkg::dp_status_type status,
   output nfe_pkg::cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ADD,
      ST_EVAL,
      ST_SQRT,
      ST_DIV_START,
      ST_DIV,
      ST_ACCUM,
      ST_NEXT,
      ST_READ_BEST,
      ST_WIDTH,
      ST_RANGE,
      ST_DDIV_START,
      ST_DDIV,
      ST_TAY_INIT,
      ST_TAY_MUL,
      ST_TAY_DIV_START,
      ST_TAY_DIV,
      ST_TAY_ACC,
      ST_EXP_MUL,
      ST_DENS,
      ST_MESH_MUL,
      ST_MESH_ADD,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      cmd          = nfe_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = nfe_pkg::CMD_ACCEPT;
               state_in = status.req_query ? ST_READ : ST_FINISH;
            end
         end
         ST_READ: begin
            cmd      = nfe_pkg::CMD_READ;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd      = nfe_pkg::CMD_SQUARE;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd      = nfe_pkg::CMD_ADD;
            state_in = status.last_dim ? ST_EVAL : ST_SQUARE;
         end
         ST_EVAL: begin
            cmd      = nfe_pkg::CMD_EVAL;
            state_in = (status.s_zero || status.q_zero) ? ST_NEXT : ST_SQRT;
         end
         ST_SQRT: begin
            if (!status.sqrt_busy) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd      = nfe_pkg::CMD_DIV_START;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd      = nfe_pkg::CMD_ACCUM;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (status.last_nucleus) begin
               state_in = ST_READ_BEST;
            end else begin
               cmd      = nfe_pkg::CMD_NEXT;
               state_in = ST_READ;
            end
         end
         ST_READ_BEST: begin
            cmd      = nfe_pkg::CMD_READ_BEST;
            state_in = ST_WIDTH;
         end
         ST_WIDTH: begin
            cmd      = nfe_pkg::CMD_WIDTH;
            state_in = status.width_zero ? ST_MESH_MUL : ST_RANGE;
         end
         ST_RANGE: begin
            state_in = status.out_of_range ? ST_MESH_MUL : ST_DDIV_START;
         end
         ST_DDIV_START: begin
            cmd      = nfe_pkg::CMD_DDIV_START;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            if (!status.div_busy) begin
               state_in = ST_TAY_INIT;
            end
         end
         ST_TAY_INIT: begin
            cmd      = nfe_pkg::CMD_TAY_INIT;
            state_in = ST_TAY_MUL;
         end
         ST_TAY_MUL: begin
            cmd      = nfe_pkg::CMD_TAY_MUL;
            state_in = ST_TAY_DIV_START;
         end
         ST_TAY_DIV_START: begin
            cmd      = nfe_pkg::CMD_TAY_DIV_START;
            state_in = ST_TAY_DIV;
         end
         ST_TAY_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_TAY_ACC;
            end
         end
         ST_TAY_ACC: begin
            cmd      = nfe_pkg::CMD_TAY_ACC;
            state_in = status.last_term ? ST_EXP_MUL : ST_TAY_MUL;
         end
         ST_EXP_MUL: begin
            cmd      = nfe_pkg::CMD_EXP_MUL;
            state_in = ST_DENS;
         end
         ST_DENS: begin
            cmd      = nfe_pkg::CMD_DENS;
            state_in = ST_MESH_MUL;
         end
         ST_MESH_MUL: begin
            cmd      = nfe_pkg::CMD_MESH_MUL;
            state_in = ST_MESH_ADD;
         end
         ST_MESH_ADD: begin
            cmd      = nfe_pkg::CMD_MESH_ADD;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // load the result register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd          = nfe_pkg::CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/nuclei_field_evaluator.sv =====
// ----------------------------------------------------------------------------
// nuclei_field_evaluator: Coulomb potential, density and mesh length
// Nucleus table with load and query transactions and two APB registers.
//
//   channel  | ports                        | direction | transaction
//   ---------+------------------------------+-----------+------------------
//   request  | req_valid/req_stall/req_data | in        | load or query
//   response | rsp_valid/rsp_stall/rsp_data | out       | one per request
//   config   | psel/penable/pwrite/paddr... | in        | register write/read
//
// A query walks the nucleus table: a 33-step square root and a 40-step
// divide for a charged nucleus at nonzero distance, then a 68-step
// divide and twelve series terms on the shared divider for the density.
// One transaction is worked at a time; the next is taken while a result
// waits in the output register. Reset clears control state only.
// ----------------------------------------------------------------------------
module nuclei_field_evaluator #(
   parameter int MAX_NUCLEI = 64,
   parameter int MAX_DIMS   = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nfe_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nfe_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [6:0] num_nuclei_ff;
   logic [1:0] active_dims_ff;
   logic       cfg_write;

   // register writes
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nuclei_ff  <= 7'd1;
         active_dims_ff <= 2'd3;
      end else if (cfg_write) begin
         if (paddr[2] == nfe_pkg::REG_NUM_NUCLEI) begin
            num_nuclei_ff <= pwdata[6:0];
         end else begin
            active_dims_ff <= pwdata[1:0];
         end
      end
   end

   // register reads
   assign prdata = (paddr[2] == nfe_pkg::REG_ACTIVE_DIMS) ? {30'b0, active_dims_ff}
                                                          : {25'b0, num_nuclei_ff};

   nfe_pkg::cmd_type       cmd;
   nfe_pkg::dp_status_type status;

   nfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nfe_dpath #(
      .MAX_NUCLEI (MAX_NUCLEI),
      .MAX_DIMS   (MAX_DIMS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .num_nuclei  (num_nuclei_ff),
      .active_dims (active_dims_ff),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule
